// ===== src/ilir_pkg.sv =====
// Shared types and constants for the indexed list insert/remove block.
`default_nettype none

package ilir_pkg;

  localparam int KindW   = 3;
  localparam int PosW    = 4;
  localparam int ValW    = 32;
  localparam int StatusW = 3;
  localparam int CountW  = 5;
  localparam int CapW    = 5;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic [KindW-1:0] {
    KIND_GET    = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_EDIT   = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_SEARCH = 3'd4,
    KIND_SORT   = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_EMPTY    = 3'd1,
    STATUS_BADPOS   = 3'd2,
    STATUS_OVERFLOW = 3'd3,
    STATUS_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic exec;
    logic sort_step;
    logic sort_phase;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic swapped;
  } ctl_stat_t;

endpackage

`default_nettype wire

// ===== src/indexed_list_insert_remove_core.sv =====
// Top level of the indexed list core: bounded ordered list with get, insert, edit,
// remove, search and sort requests.
//
// A request is transferred at a rising edge where start is high and busy is low.
// Get, insert, edit, remove and search finish at that edge; the result is registered there
// and appears in the following cycle with done_o high for exactly one cycle, and busy stays
// low, so these requests can be issued every cycle while no sort is in progress.
// Sort runs an odd-even transposition over the held entries, one compare-exchange
// round per cycle, and ends after an even and an odd round without a swap. It keeps
// busy high while it runs; its result follows in the cycle after the last round.
// The capacity register is written through the cfg channel, which is always ready;
// write it only while no request is in progress.
// Reset empties the list and sets the capacity to 16. The receiver cannot stall:
// each result is valid only in the cycle where done_o is high.
`default_nettype none

module indexed_list_insert_remove_core #(
  parameter int DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [ilir_pkg::KindW-1:0]       kind_i,
  input  wire logic [ilir_pkg::PosW-1:0]        position_i,
  input  wire logic signed [ilir_pkg::ValW-1:0] value_i,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [ilir_pkg::CapW-1:0]        cfg_data_i,
  output logic                                  done_o,
  output logic [ilir_pkg::StatusW-1:0]          status_o,
  output logic signed [ilir_pkg::ValW-1:0]      read_value_o,
  output logic [ilir_pkg::PosW-1:0]             found_position_o,
  output logic [ilir_pkg::CountW-1:0]           item_count_o
);
  import ilir_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  kind_e     kind;
  logic      busy_int;

  assign kind        = kind_e'(kind_i);
  assign cfg_ready_o = 1'b1;
  assign busy        = busy_int;

  ilir_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start && !busy_int),
    .kind_i  (kind),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_int)
  );

  ilir_datapath #(
    .Depth (DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .kind_i           (kind),
    .position_i       (position_i),
    .value_i          (value_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .read_value_o     (read_value_o),
    .found_position_o (found_position_o),
    .item_count_o     (item_count_o)
  );

endmodule

`default_nettype wire

// ===== src/ilir_ctrl.sv =====
// Controller state machine that sequences requests and the transposition sort.
`default_nettype none

module ilir_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire ilir_pkg::kind_e   kind_i,
  input  wire ilir_pkg::ctl_stat_t stat_i,
  output ilir_pkg::ctl_cmd_t     cmd_o,
  output logic                   busy_o
);
  import ilir_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SORT
  } state_e;

  state_e state_q;
  logic   phase_q;
  logic   quiet_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.exec       = (state_q == ST_IDLE) && start_i && (kind_i != KIND_SORT);
    cmd_o.sort_step  = (state_q == ST_SORT);
    cmd_o.sort_phase = phase_q;
    cmd_o.finish     = (state_q == ST_SORT) && quiet_q && !stat_i.swapped;
  end

  assign busy_o = (state_q == ST_SORT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
      quiet_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i && (kind_i == KIND_SORT)) begin
            state_q <= ST_SORT;
            phase_q <= 1'b0;
            quiet_q <= 1'b0;
          end
        end
        ST_SORT: begin
          // The list is ordered once an even and an odd round both pass without a swap.
          if (quiet_q && !stat_i.swapped) begin
            state_q <= ST_IDLE;
          end else begin
            quiet_q <= !stat_i.swapped;
            phase_q <= !phase_q;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/ilir_datapath.sv =====
// Datapath with the entry cells, item count, capacity register and result registers.
`default_nettype none

module ilir_datapath #(
  parameter int Depth = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ilir_pkg::ctl_cmd_t               cmd_i,
  output ilir_pkg::ctl_stat_t                   stat_o,
  input  wire ilir_pkg::kind_e                  kind_i,
  input  wire logic [ilir_pkg::PosW-1:0]        position_i,
  input  wire logic signed [ilir_pkg::ValW-1:0] value_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [ilir_pkg::CapW-1:0]        cfg_data_i,
  output logic                                  done_o,
  output logic [ilir_pkg::StatusW-1:0]          status_o,
  output logic signed [ilir_pkg::ValW-1:0]      read_value_o,
  output logic [ilir_pkg::PosW-1:0]             found_position_o,
  output logic [ilir_pkg::CountW-1:0]           item_count_o
);
  import ilir_pkg::*;

  localparam int IW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);
  localparam int XW = ((CW > CapW) ? CW : CapW) + 1;

  logic [ValW-1:0]    entries_q [Depth];
  logic [ValW-1:0]    entries_d [Depth];
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      count_d;
  logic [CapW-1:0]    cap_q;
  logic               done_q;
  status_e            status_q;
  logic [ValW-1:0]    rd_q;
  logic [PosW-1:0]    fp_q;
  logic [CountW-1:0]  cnt_out_q;

  status_e            st;
  logic [ValW-1:0]    rd;
  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      cnt_x;
  logic [XW-1:0]      cfg_x;
  logic [XW-1:0]      cap_x;
  logic [IW-1:0]      pos_idx;
  logic               hit;
  logic [IW-1:0]      hit_idx;
  logic               any_swap;

  assign pos_x   = XW'(position_i);
  assign cnt_x   = XW'(count_q);
  assign cfg_x   = XW'(cap_q);
  assign pos_idx = pos_x[IW-1:0];

  always_comb begin
    if (cfg_x == '0) begin
      cap_x = XW'(1);
    end else if (cfg_x > XW'(Depth)) begin
      cap_x = XW'(Depth);
    end else begin
      cap_x = cfg_x;
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if ((XW'(i) < cnt_x) && (entries_q[i] == value_i)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    st        = STATUS_OK;
    rd        = '0;
    any_swap  = 1'b0;
    for (int i = 0; i < Depth - 1; i++) begin
      if ((1'(i) == cmd_i.sort_phase) && (XW'(i + 1) < cnt_x) &&
          ($signed(entries_q[i + 1]) < $signed(entries_q[i]))) begin
        any_swap = 1'b1;
        if (cmd_i.sort_step) begin
          entries_d[i]     = entries_q[i + 1];
          entries_d[i + 1] = entries_q[i];
        end
      end
    end
    if (cmd_i.exec) begin
      case (kind_i)
        KIND_GET: begin
          if (cnt_x == '0) begin
            st = STATUS_EMPTY;
          end else if (pos_x >= cnt_x) begin
            st = STATUS_BADPOS;
          end else begin
            rd = entries_q[pos_idx];
          end
        end
        KIND_INSERT: begin
          if (cnt_x >= cap_x) begin
            st = STATUS_OVERFLOW;
          end else if ((pos_x >= cap_x) || (pos_x > cnt_x)) begin
            st = STATUS_BADPOS;
          end else begin
            for (int i = 1; i < Depth; i++) begin
              if (XW'(i) > pos_x) begin
                entries_d[i] = entries_q[i - 1];
              end
            end
            entries_d[pos_idx] = value_i;
            count_d            = CW'(count_q + 1'b1);
          end
        end
        KIND_EDIT: begin
          if (pos_x >= cnt_x) begin
            st = STATUS_BADPOS;
          end else begin
            entries_d[pos_idx] = value_i;
          end
        end
        KIND_REMOVE: begin
          if (pos_x >= cnt_x) begin
            st = STATUS_BADPOS;
          end else begin
            for (int i = 0; i < Depth - 1; i++) begin
              if (XW'(i) >= pos_x) begin
                entries_d[i] = entries_q[i + 1];
              end
            end
            count_d = CW'(count_q - 1'b1);
          end
        end
        KIND_SEARCH: begin
          if (cnt_x == '0) begin
            st = STATUS_EMPTY;
          end else if (!hit) begin
            st = STATUS_NOTFOUND;
          end
        end
        default: begin
          st = STATUS_OK;
        end
      endcase
    end
  end

  assign stat_o.swapped = any_swap;

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
    if (cmd_i.exec) begin
      status_q  <= st;
      rd_q      <= rd;
      fp_q      <= ((kind_i == KIND_SEARCH) && (st == STATUS_OK)) ? PosW'(hit_idx) : '0;
      cnt_out_q <= CountW'(count_d);
    end else if (cmd_i.finish) begin
      status_q  <= STATUS_OK;
      rd_q      <= '0;
      fp_q      <= '0;
      cnt_out_q <= CountW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CapReset;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.exec || cmd_i.finish;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign read_value_o     = rd_q;
  assign found_position_o = fp_q;
  assign item_count_o     = cnt_out_q;

endmodule

`default_nettype wire
